FILE: rtl/pirc_pkg.sv
// Package for the packet ID repeat counter.
// Holds the entry and cell control types, the codes and the result limit.
// No dependencies.
package pirc_pkg;

    localparam int ID_W = 16;
    localparam int CNT_W = 16;
    localparam int MAX_RESULTS = 32;
    localparam int FOUND_W = $clog2(MAX_RESULTS + 1);
    localparam logic [FOUND_W-1:0] FOUND_MAX = FOUND_W'(MAX_RESULTS);
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [15:0] THRESHOLD_RESET = 16'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_REPORT = 1'b1;
    localparam logic KIND_ALERT = 1'b0;
    localparam logic KIND_NONE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECORD,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic             used;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic            record;
        logic            shift;
        logic            any_match;
        logic [ID_W-1:0] key;
    } cell_ctrl_t;

endpackage

FILE: rtl/pirc_cell.sv
// One table cell: holds an ID, its count and a used flag.
// Depends on pirc_pkg for the entry and control types.
module pirc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  pirc_pkg::cell_ctrl_t ctrl,
    input  logic                prev_used,
    input  pirc_pkg::entry_t    right_in,
    output pirc_pkg::entry_t    cur,
    output logic                match
);

    logic                      used_reg, used_next;
    logic [pirc_pkg::ID_W-1:0] id_reg, id_next;
    logic [pirc_pkg::CNT_W-1:0] count_reg, count_next;

    assign match = used_reg && (id_reg == ctrl.key);

    always_comb begin
        used_next = used_reg;
        id_next = id_reg;
        count_next = count_reg;
        if (ctrl.shift) begin
            used_next = right_in.used;
            id_next = right_in.id;
            count_next = right_in.count;
        end else if (ctrl.record) begin
            if (match) begin
                if (count_reg != pirc_pkg::CNT_SAT) begin
                    count_next = count_reg + pirc_pkg::CNT_ONE;
                end
            end else if (!ctrl.any_match && !used_reg && prev_used) begin
                used_next = 1'b1;
                id_next = ctrl.key;
                count_next = pirc_pkg::CNT_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
        count_reg <= count_next;
    end

    assign cur.used = used_reg;
    assign cur.id = id_reg;
    assign cur.count = count_reg;

endmodule

FILE: rtl/pirc_chain.sv
// Row of table cells linked to their neighbors; shifts toward the head on a report.
// Depends on pirc_pkg and pirc_cell.
module pirc_chain #(
    parameter int DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 record,
    input  logic                 shift,
    input  logic [pirc_pkg::ID_W-1:0] key,
    output pirc_pkg::entry_t     head,
    output logic                 any_match,
    output logic                 full
);

    pirc_pkg::entry_t     ent [DEPTH];
    logic [DEPTH-1:0]     match_vec;
    pirc_pkg::cell_ctrl_t ctrl;
    pirc_pkg::entry_t     empty_ent;

    assign any_match = |match_vec;
    assign ctrl.record = record;
    assign ctrl.shift = shift;
    assign ctrl.any_match = any_match;
    assign ctrl.key = key;
    assign empty_ent = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic             prev_used;
        pirc_pkg::entry_t right_in;
        if (k == 0) begin : g_first
            assign prev_used = 1'b1;
        end else begin : g_mid
            assign prev_used = ent[k-1].used;
        end
        if (k == DEPTH - 1) begin : g_tail
            assign right_in = empty_ent;
        end else begin : g_body
            assign right_in = ent[k+1];
        end
        pirc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .prev_used (prev_used),
            .right_in  (right_in),
            .cur       (ent[k]),
            .match     (match_vec[k])
        );
    end

    assign head = ent[0];
    assign full = ent[DEPTH-1].used;

endmodule

FILE: rtl/packet_id_repeat_counter_unit.sv
// Packet ID repeat counter: a record item registers its ID, then updates the cell row.
// A report item scans the row: it shifts one entry per cycle past the head unless an output
// stall holds it, and the head is the only place results are taken from.
// The scan also empties the row, so the next batch starts clean.
// Synchronous active-low reset clears all used flags, the overflow flag and the control state,
// and sets the alert threshold to 2. Depends on pirc_pkg and pirc_chain.
module packet_id_repeat_counter_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_id_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [15:0] m_alert_id,
    output logic [15:0] m_alert_count,
    output logic        m_overflowed,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_alert_threshold
);

    pirc_pkg::state_t state_reg, state_next;
    logic [15:0] thr_reg;
    logic [pirc_pkg::ID_W-1:0] key_reg, key_next;
    logic stopped_reg, stopped_next;
    logic [pirc_pkg::FOUND_W-1:0] found_reg, found_next;
    logic pend_valid_reg, pend_valid_next;
    logic [pirc_pkg::ID_W-1:0] pend_id_reg, pend_id_next;
    logic [pirc_pkg::CNT_W-1:0] pend_count_reg, pend_count_next;
    logic m_valid_reg, m_valid_next;
    logic m_kind_reg, m_kind_next;
    logic [15:0] m_id_reg, m_id_next;
    logic [15:0] m_count_reg, m_count_next;
    logic m_ovf_reg, m_ovf_next;
    logic m_last_reg, m_last_next;

    pirc_pkg::entry_t head;
    logic any_match, full;
    logic record_en, shift_en, out_free, qual, s_fire, scan_done;

    assign s_ready = (state_reg == pirc_pkg::ST_IDLE);
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign qual = head.used && (head.count > thr_reg) && (found_reg < pirc_pkg::FOUND_MAX);
    assign record_en = (state_reg == pirc_pkg::ST_RECORD) && (key_reg != '0) && !stopped_reg;
    assign shift_en = (state_reg == pirc_pkg::ST_SCAN) && head.used
                      && !(qual && pend_valid_reg && !out_free);
    assign scan_done = (state_reg == pirc_pkg::ST_SCAN) && !head.used && out_free;

    pirc_chain #(
        .DEPTH (TABLE_DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .record    (record_en),
        .shift     (shift_en),
        .key       (key_reg),
        .head      (head),
        .any_match (any_match),
        .full      (full)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pirc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_op == pirc_pkg::OP_REPORT) ? pirc_pkg::ST_SCAN
                                                               : pirc_pkg::ST_RECORD;
                end
            end
            pirc_pkg::ST_RECORD: begin
                state_next = pirc_pkg::ST_IDLE;
            end
            pirc_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = pirc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pirc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        key_next = s_fire ? s_id_value : key_reg;
        stopped_next = stopped_reg;
        found_next = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next = pend_id_reg;
        pend_count_next = pend_count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next = m_kind_reg;
        m_id_next = m_id_reg;
        m_count_next = m_count_reg;
        m_ovf_next = m_ovf_reg;
        m_last_next = m_last_reg;
        case (state_reg)
            pirc_pkg::ST_RECORD: begin
                if (record_en && !any_match && full) begin
                    stopped_next = 1'b1;
                end
            end
            pirc_pkg::ST_SCAN: begin
                if (shift_en && qual) begin
                    found_next = found_reg + pirc_pkg::FOUND_W'(1);
                    pend_valid_next = 1'b1;
                    pend_id_next = head.id;
                    pend_count_next = head.count;
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_kind_next = pirc_pkg::KIND_ALERT;
                        m_id_next = pend_id_reg;
                        m_count_next = pend_count_reg;
                        m_ovf_next = stopped_reg;
                        m_last_next = 1'b0;
                    end
                end else if (scan_done) begin
                    m_valid_next = 1'b1;
                    m_ovf_next = stopped_reg;
                    m_last_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_kind_next = pirc_pkg::KIND_ALERT;
                        m_id_next = pend_id_reg;
                        m_count_next = pend_count_reg;
                    end else begin
                        m_kind_next = pirc_pkg::KIND_NONE;
                        m_id_next = '0;
                        m_count_next = '0;
                    end
                    stopped_next = 1'b0;
                    found_next = '0;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pirc_pkg::ST_IDLE;
            thr_reg <= pirc_pkg::THRESHOLD_RESET;
            stopped_reg <= 1'b0;
            found_reg <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_alert_threshold;
            end
            stopped_reg <= stopped_next;
            found_reg <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pend_id_reg <= pend_id_next;
        pend_count_reg <= pend_count_next;
        m_kind_reg <= m_kind_next;
        m_id_reg <= m_id_next;
        m_count_reg <= m_count_next;
        m_ovf_reg <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind = m_kind_reg;
    assign m_alert_id = m_id_reg;
    assign m_alert_count = m_count_reg;
    assign m_overflowed = m_ovf_reg;
    assign m_last = m_last_reg;

endmodule
